>>> design/crf_pkg.sv
// shared constants and the cordic angle table for the complementary roll filter
// no dependencies; imported by every module of the block

package crf_pkg;

    localparam int CrfCordicSteps   = 24;
    localparam int CrfAngleFracBits = 16;
    localparam int CrfTabFrac       = 24;
    localparam int CrfDegHalf       = 180;
    localparam int CrfDegQuarter    = 90;

    localparam int CrfInW     = 80;
    localparam int CrfOutW    = 64;
    localparam int CrfWeightW = 17;
    localparam int CrfDtW     = 24;

    localparam logic [CrfWeightW-1:0] CrfWeightReset = 17'd58982;
    localparam logic [CrfWeightW-1:0] CrfWeightOne   = 17'd65536;

    // atan(2^-i) in degrees, 24 fractional bits
    function automatic logic [31:0] crf_atan_deg(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489088;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            5'd20: v = 32'd917;
            5'd21: v = 32'd458;
            5'd22: v = 32'd229;
            5'd23: v = 32'd115;
            5'd24: v = 32'd57;
            5'd25: v = 32'd29;
            5'd26: v = 32'd14;
            5'd27: v = 32'd7;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/crf_mul.sv
// serial shift-add multiplier, signed multiplicand by unsigned multiplier
// one partial product per cycle; uses crf_pkg

module crf_mul #(
    parameter int A_W = 35,
    parameter int B_W = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [A_W-1:0]       a,
    input  logic        [B_W-1:0]       b,
    output logic                        busy,
    output logic signed [A_W+B_W-1:0]   prod
);
    import crf_pkg::*;

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic                    busy_reg;
    logic                    busy_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [P_W-1:0]   a_sh_reg;
    logic [B_W-1:0]          b_sh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(B_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= '0;
            a_sh_reg <= P_W'(a);
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                prod_reg <= prod_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg <<< 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign prod = prod_reg;

endmodule

>>> design/crf_cordic.sv
// iterative vectoring cordic: atan2(acc_x, acc_y) in degrees, one rotation per cycle
// uses crf_pkg for the angle table and angle constants

module crf_cordic #(
    parameter int STEPS = 24,
    parameter int FRAC  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [15:0]     acc_x,
    input  logic signed [15:0]     acc_y,
    output logic                   busy,
    output logic signed [FRAC+9:0] angle
);
    import crf_pkg::*;

    localparam int XY_W  = 51;
    localparam int Z_W   = 34;
    localparam int ANG_W = FRAC + 10;
    localparam int SH    = CrfTabFrac - FRAC;
    localparam int CNT_W = $clog2(STEPS + 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ITER = 2'd1;
    localparam logic [1:0] C_RND  = 2'd2;
    localparam logic [1:0] C_CLMP = 2'd3;

    localparam logic signed [Z_W-1:0] ZQUART = Z_W'(CrfDegQuarter) <<< CrfTabFrac;
    localparam logic signed [Z_W-1:0] ZLIM   = Z_W'(CrfDegHalf) <<< FRAC;
    localparam logic signed [Z_W-1:0] ZHALF  = (Z_W'(1) <<< SH) >>> 1;

    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic signed [XY_W-1:0]  x_next;
    logic signed [XY_W-1:0]  y_next;
    logic signed [Z_W-1:0]   z_next;
    logic                    zero_reg;
    logic signed [ANG_W-1:0] angle_reg;

    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic [4:0]              idx;
    logic signed [Z_W-1:0]   step_ang;
    logic signed [Z_W-1:0]   z_clamp;

    assign idx      = 5'(cnt_reg);
    assign step_ang = Z_W'(crf_atan_deg(idx));
    assign dx       = y_reg >>> idx;
    assign dy       = x_reg >>> idx;
    assign xs       = XY_W'(acc_y) <<< 32;
    assign ys       = XY_W'(acc_x) <<< 32;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    phase_next = C_ITER;
                    cnt_next   = '0;
                end
            end
            C_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    phase_next = C_RND;
                end
            end
            C_RND:
            begin
                phase_next = C_CLMP;
            end
            C_CLMP:
            begin
                phase_next = C_IDLE;
            end
            default:
            begin
                phase_next = C_IDLE;
            end
        endcase
    end

    // pre-rotation on start, then one micro-rotation per step, then rounding
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (phase_reg == C_IDLE)
        begin
            if (acc_y < 0)
            begin
                if (acc_x >= 0)
                begin
                    x_next = ys;
                    y_next = -xs;
                    z_next = ZQUART;
                end
                else
                begin
                    x_next = -ys;
                    y_next = xs;
                    z_next = -ZQUART;
                end
            end
            else
            begin
                x_next = xs;
                y_next = ys;
                z_next = '0;
            end
        end
        else if (phase_reg == C_ITER)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_ang;
            end
        end
        else if (phase_reg == C_RND)
        begin
            z_next = (z_reg + ZHALF) >>> SH;
        end
    end

    always_comb
    begin
        if (z_reg > ZLIM)
        begin
            z_clamp = ZLIM;
        end
        else if (z_reg < -ZLIM)
        begin
            z_clamp = -ZLIM;
        end
        else
        begin
            z_clamp = z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((phase_reg == C_IDLE && start) || phase_reg == C_ITER || phase_reg == C_RND)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (phase_reg == C_IDLE && start)
        begin
            zero_reg <= (acc_x == 16'sd0) && (acc_y == 16'sd0);
        end
        if (phase_reg == C_CLMP)
        begin
            angle_reg <= zero_reg ? '0 : ANG_W'(z_clamp);
        end
    end

    assign busy  = (phase_reg != C_IDLE);
    assign angle = angle_reg;

endmodule

>>> design/complementary_roll_filter.sv
// complementary roll filter: takes one request at a time, the next once the last result
// is stored; the pace is set by two 24-step passes of the serial multiplier
// (gyro step, then blend); the cordic runs beside the first pass
// one result register parts the output side; a held result stalls only the final store
// rst_n is asynchronous, active low: roll estimate clears to zero, blend weight to 58982
// uses crf_pkg, crf_mul and crf_cordic

module complementary_roll_filter #(
    parameter int CORDIC_STEPS    = crf_pkg::CrfCordicSteps,
    parameter int ANGLE_FRAC_BITS = crf_pkg::CrfAngleFracBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // acc_x[15:0], acc_y[31:16], gyro_z[55:32], sample_period[79:56]
    input  logic [crf_pkg::CrfInW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // roll_filtered[31:0], roll_from_accel[56:32], zero[63:57]
    output logic [crf_pkg::CrfOutW-1:0]   m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [crf_pkg::CrfWeightW-1:0] cfg_wdata
);
    import crf_pkg::*;

    localparam int ACC_W = ANGLE_FRAC_BITS + 10;
    localparam int GS    = 32 - ANGLE_FRAC_BITS;
    localparam int GT_W  = 49 - GS;
    localparam int GYR_W = (GT_W > 32 ? GT_W : 32) + 1;
    localparam int DIF_W = (GYR_W > ACC_W ? GYR_W : ACC_W) + 1;
    localparam int P_W   = DIF_W + CrfDtW;
    localparam int SUM_W = P_W + 1;
    localparam int MIX_W = SUM_W - 16;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_GSUM = 4'd2;
    localparam logic [3:0] S_DIFF = 4'd3;
    localparam logic [3:0] S_M2S  = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_SAT  = 4'd6;

    localparam logic signed [P_W-1:0]   GHALF = P_W'(1) <<< (GS - 1);
    localparam logic signed [SUM_W-1:0] BHALF = SUM_W'(32768);

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic signed [31:0]        roll_reg;
    logic [CrfWeightW-1:0]     weight_reg;
    logic                      out_valid_reg;
    logic signed [31:0]        out_roll_reg;
    logic signed [24:0]        out_acc_reg;

    logic signed [GT_W-1:0]    rnd_reg;
    logic signed [GYR_W-1:0]   gyr_reg;
    logic signed [DIF_W-1:0]   diff_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [MIX_W-1:0]   mix_reg;

    logic signed [15:0]        in_acc_x;
    logic signed [15:0]        in_acc_y;
    logic signed [23:0]        in_gyro;
    logic [CrfDtW-1:0]         in_period;

    logic                      in_req;
    logic                      out_load;
    logic                      mul_start;
    logic signed [DIF_W-1:0]   mul_a;
    logic [CrfDtW-1:0]         mul_b;
    logic                      mul_busy;
    logic signed [P_W-1:0]     mul_prod;
    logic                      cor_busy;
    logic signed [ACC_W-1:0]   cor_angle;
    logic [CrfWeightW-1:0]     alpha;
    logic signed [SUM_W-1:0]   blend_sum;
    logic                      ovf;
    logic signed [31:0]        roll_sat;

    assign in_acc_x  = s_axis_tdata[15:0];
    assign in_acc_y  = s_axis_tdata[31:16];
    assign in_gyro   = s_axis_tdata[55:32];
    assign in_period = s_axis_tdata[79:56];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_SAT) && (!out_valid_reg || m_axis_tready);

    // alpha above one acts as one
    assign alpha     = (weight_reg > CrfWeightOne) ? CrfWeightOne : weight_reg;
    assign mul_start = in_req || (state_reg == S_M2S);
    assign mul_a     = (state_reg == S_IDLE) ? DIF_W'(in_gyro) : diff_reg;
    assign mul_b     = (state_reg == S_IDLE) ? in_period : CrfDtW'(alpha);

    crf_mul #(
        .A_W (DIF_W),
        .B_W (CrfDtW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    crf_cordic #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_req),
        .acc_x (in_acc_x),
        .acc_y (in_acc_y),
        .busy  (cor_busy),
        .angle (cor_angle)
    );

    // 65536*acc + alpha*(gyr - acc), rounded half up by 2^16
    assign blend_sum = (SUM_W'(acc_reg) <<< 16) + SUM_W'(mul_prod) + BHALF;

    assign ovf      = !(&mix_reg[MIX_W-1:31]) && (|mix_reg[MIX_W-1:31]);
    assign roll_sat = ovf ? (mix_reg[MIX_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                          : mix_reg[31:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (!mul_busy)
                begin
                    state_next = S_GSUM;
                end
            end
            S_GSUM:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (!cor_busy)
                begin
                    state_next = S_M2S;
                end
            end
            S_M2S:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (!mul_busy)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            roll_reg      <= '0;
            weight_reg    <= CrfWeightReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                weight_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                roll_reg      <= roll_sat;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1 && !mul_busy)
        begin
            rnd_reg <= GT_W'((mul_prod + GHALF) >>> GS);
        end
        if (state_reg == S_GSUM)
        begin
            gyr_reg <= GYR_W'(roll_reg) + GYR_W'(rnd_reg);
        end
        if (state_reg == S_DIFF && !cor_busy)
        begin
            diff_reg <= DIF_W'(gyr_reg) - DIF_W'(cor_angle);
            acc_reg  <= cor_angle;
        end
        if (state_reg == S_MUL2 && !mul_busy)
        begin
            mix_reg <= MIX_W'(blend_sum >>> 16);
        end
        if (out_load)
        begin
            out_roll_reg <= roll_sat;
            out_acc_reg  <= 25'(acc_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_acc_reg, out_roll_reg};

endmodule

>>> design/crf_checker.sv
// port-level assertions for the complementary roll filter
// uses crf_pkg; bound to complementary_roll_filter at the end of this file

module crf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [crf_pkg::CrfOutW-1:0]   m_axis_tdata
);
    import crf_pkg::*;

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a request");

    // a result never shows up in the cycle after a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result too early after request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // pad bits above the two result fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CrfOutW-1:57] == '0))
        else $error("result pad bits not zero");

endmodule

bind complementary_roll_filter crf_checker u_crf_checker (.*);

>>> test/tb_complementary_roll_filter.sv
// testbench for complementary_roll_filter: directed table, then random imu samples per weight
// predicts roll per sample in place, checks every result in order; needs crf_pkg and the block

module tb_complementary_roll_filter;

    import crf_pkg::*;

    localparam int  WatchdogLimit = 2000;
    localparam int  TailCycles    = 60;
    localparam int  RandomPhases  = 8;
    localparam int  ItemsPerPhase = 212;
    localparam int  MaxPrinted    = 30;
    localparam longint WeightOne  = 65536;
    localparam longint RollMax    = 64'sd2147483647;
    localparam longint RollMin    = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] filtered;
        logic signed [24:0] accel;
    } roll_result_t;

    typedef struct {
        bit                 set_weight;
        logic [16:0]        weight;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [23:0] rate;
        logic [23:0]        dt;
        bit                 typed;
        logic signed [31:0] e_roll;
        logic signed [24:0] e_acc;
    } sample_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [CrfInW-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [CrfOutW-1:0]    m_axis_tdata;
    logic                  cfg_we;
    logic [CrfWeightW-1:0] cfg_wdata;

    roll_result_t          roll_expected[$];
    sample_row_t           directed_rows[$];
    longint                atan_table[32];
    logic signed [31:0]    roll_state;
    logic [CrfWeightW-1:0] gyro_weight;
    bit                    source_stalls;
    bit                    sink_stalls;
    int                    err_count;
    int                    samples_sent;
    int                    results_checked;
    int                    weight_writes;
    int                    quiet_cycles;

    complementary_roll_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // vectoring cordic on (acc_y, acc_x), degrees in q.16
    function automatic longint accel_roll_angle(input logic signed [15:0] sx,
                                                input logic signed [15:0] cy);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint lim;
        int     i;
        x = longint'(cy) <<< 32;
        y = longint'(sx) <<< 32;
        z = 0;
        if (sx == 0 && cy == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x;
                x = y;
                y = -t;
                z = longint'(CrfDegQuarter) <<< CrfTabFrac;
            end
            else
            begin
                t = x;
                x = -y;
                y = t;
                z = -(longint'(CrfDegQuarter) <<< CrfTabFrac);
            end
        end
        for (i = 0; i < CrfCordicSteps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_table[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_table[i];
            end
        end
        z = round_half_up(z, CrfTabFrac - CrfAngleFracBits);
        lim = longint'(CrfDegHalf) <<< CrfAngleFracBits;
        if (z > lim)
            z = lim;
        if (z < -lim)
            z = -lim;
        return z;
    endfunction

    // advances the roll estimate by one sample
    function automatic roll_result_t predict_roll(input logic [CrfInW-1:0] word);
        roll_result_t       res;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [23:0] rate;
        logic [23:0]        dt;
        longint             acc;
        longint             gyr;
        longint             alpha;
        longint             mix;
        ax   = word[15:0];
        ay   = word[31:16];
        rate = word[55:32];
        dt   = word[79:56];
        acc  = accel_roll_angle(ax, ay);
        gyr  = longint'(roll_state)
             + round_half_up(longint'(dt) * longint'(rate), 32 - CrfAngleFracBits);
        alpha = (gyro_weight > CrfWeightOne) ? WeightOne : longint'(gyro_weight);
        mix   = round_half_up(alpha * gyr + (WeightOne - alpha) * acc, 16);
        if (mix > RollMax)
            mix = RollMax;
        if (mix < RollMin)
            mix = RollMin;
        roll_state   = mix[31:0];
        res.filtered = mix[31:0];
        res.accel    = acc[24:0];
        return res;
    endfunction

    function automatic logic [CrfInW-1:0] random_sample();
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] r3;
        int          pick;
        r0 = $urandom();
        r1 = $urandom();
        r2 = $urandom();
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            r0 = 0;
            r1 = 0;
        end
        else if (pick < 4)
            r0 = 0;
        else if (pick < 6)
            r1 = 0;
        else if (pick < 9)
        begin
            r0 = $urandom_range(0, 8) - 4;
            r1 = $urandom_range(0, 8) - 4;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
            r3 = $urandom_range(0, 65535);
        else if (pick < 7)
            r3 = $urandom();
        else if (pick < 8)
            r3 = 0;
        else if (pick < 9)
            r3 = 32'hFFFFFF;
        else
            r3 = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0)
            r2 = $urandom_range(0, 4096) - 2048;
        return {r3[23:0], r2[23:0], r1[15:0], r0[15:0]};
    endfunction

    task automatic add_row(input bit sw, input int w, input int ax, input int ay,
                           input int rate, input int dt, input bit typed,
                           input int e_roll, input int e_acc);
        sample_row_t row;
        row.set_weight = sw;
        row.weight     = w[16:0];
        row.ax         = ax[15:0];
        row.ay         = ay[15:0];
        row.rate       = rate[23:0];
        row.dt         = dt[23:0];
        row.typed      = typed;
        row.e_roll     = e_roll;
        row.e_acc      = e_acc[24:0];
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MaxPrinted)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_checked, what, got, want);
        err_count++;
    endtask

    task automatic offer_sample(input logic [CrfInW-1:0] word, input bit typed,
                                input roll_result_t typed_want);
        roll_result_t want;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = predict_roll(word);
        if (typed)
            want = typed_want;
        roll_expected.push_back(want);
        samples_sent++;
    endtask

    task automatic hold_off();
        if (source_stalls && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (roll_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_weight(input logic [CrfWeightW-1:0] w);
        cfg_wdata <= w;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        gyro_weight = w;
        weight_writes++;
    endtask

    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        roll_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (roll_expected.size() == 0)
                report_mismatch("result with no request waiting",
                                $signed(m_axis_tdata[31:0]), 0);
            else
            begin
                want = roll_expected.pop_front();
                if (m_axis_tdata[31:0] !== want.filtered)
                    report_mismatch("roll_filtered", $signed(m_axis_tdata[31:0]),
                                    want.filtered);
                if (m_axis_tdata[56:32] !== want.accel)
                    report_mismatch("roll_from_accel", $signed(m_axis_tdata[56:32]),
                                    want.accel);
                if (m_axis_tdata[63:57] !== 7'd0)
                    report_mismatch("padding bits", m_axis_tdata[63:57], 0);
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WatchdogLimit)
        begin
            $display("watchdog: nothing accepted for %0d cycles", WatchdogLimit);
            $display("complementary_roll_filter verification failed");
            $finish;
        end
    end

    initial
    begin
        sample_row_t  row;
        roll_result_t typed_want;
        int           phase;
        int           n;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        source_stalls = 1'b1;
        sink_stalls   = 1'b1;
        err_count       = 0;
        samples_sent    = 0;
        results_checked = 0;
        weight_writes   = 0;
        quiet_cycles    = 0;
        roll_state      = 0;
        gyro_weight     = CrfWeightReset;
        atan_table = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                       15018523, 7509720, 3754917, 1877466, 938734, 469367,
                       234684, 117342, 58671, 29335, 14668, 7334,
                       3667, 1833, 917, 458, 229, 115,
                       57, 29, 14, 7, 4, 2,
                       1, 0};

        // zero vector right after reset, axes, corners, half-turn clamp
        add_row(0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(0, 0, 0, 100, 0, 0, 0, 0, 0);
        add_row(0, 0, 100, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, -100, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(0, 0, -32768, -32768, 0, 0, 0, 0, 0);
        add_row(0, 0, 32767, -32768, 0, 0, 0, 0, 0);
        add_row(0, 0, -1, -32768, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, -1, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, -32768, 0, 0, 0, 0, 0);
        add_row(0, 0, -32768, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 1, 1, 0, 0, 0, 0, 0);
        // largest gyro steps, then gyro only until the roll saturates both ways
        add_row(0, 0, 0, 0, 8388607, 16777215, 0, 0, 0);
        add_row(0, 0, 0, 0, -8388608, 16777215, 0, 0, 0);
        add_row(1, 65536, 0, 0, 8388607, 16777215, 0, 0, 0);
        add_row(0, 0, 0, 0, 8388607, 16777215, 0, 0, 0);
        add_row(0, 0, 0, 0, 8388607, 16777215, 0, 0, 0);
        add_row(1, 131071, 0, 0, -8388608, 16777215, 0, 0, 0);
        add_row(0, 0, 0, 0, -8388608, 16777215, 0, 0, 0);
        add_row(0, 0, 0, 0, -8388608, 16777215, 0, 0, 0);
        add_row(0, 0, 32767, -1, 0, 0, 0, 0, 0);
        // accel only at weight 0: gyro is ignored; then half and reset weights
        add_row(1, 0, 0, 0, 8388607, 16777215, 1, 0, 0);
        add_row(0, 0, -32768, -1, -8388608, 16777215, 0, 0, 0);
        add_row(1, 32768, 12345, -23456, 1000, 16777, 0, 0, 0);
        add_row(1, 58982, -1, 1, 256, 16777, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.set_weight)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                write_weight(row.weight);
            end
            else
                hold_off();
            typed_want.filtered = row.e_roll;
            typed_want.accel    = row.e_acc;
            offer_sample({row.dt, row.rate, row.ay, row.ax}, row.typed, typed_want);
        end

        for (phase = 0; phase < RandomPhases; phase++)
        begin
            s_axis_tvalid <= 1'b0;
            wait_drained();
            case (phase)
                0: write_weight(17'($urandom_range(0, 131071)));
                1: write_weight(CrfWeightOne);
                2: write_weight(17'd0);
                3: write_weight(17'd131071);
                4: write_weight(17'd65535);
                5: write_weight(17'd1);
                6: write_weight(17'($urandom_range(0, 65536)));
                default: write_weight(CrfWeightReset);
            endcase
            source_stalls = (phase % 3 != 2) && (phase != RandomPhases - 1);
            sink_stalls   = source_stalls;
            for (n = 0; n < ItemsPerPhase; n++)
            begin
                hold_off();
                offer_sample(random_sample(), 1'b0, typed_want);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (roll_expected.size() != 0)
            report_mismatch("expected results never arrived", roll_expected.size(), 0);

        $display("%0d imu samples sent, %0d roll results checked, %0d mismatches",
                 samples_sent, results_checked, err_count);
        $display("%0d blend weight settings incl. 0, 1.0 and above one", weight_writes);
        if (err_count == 0)
            $display("complementary_roll_filter verification clean");
        else
            $display("complementary_roll_filter verification failed");
        $finish;
    end

endmodule

>>> files.f
design/crf_pkg.sv
design/crf_mul.sv
design/crf_cordic.sv
design/complementary_roll_filter.sv
design/crf_checker.sv
test/tb_complementary_roll_filter.sv
